[src/pcht_pkg.sv]
// Shared constants, codes and types of the per-context hit counter table.
// No dependencies; every other file in src/ refers to it by scoped names.
package pcht_pkg;

    localparam int MAX_ENTRIES = 24;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W   = 32;
    localparam int WCNT_W  = 21;
    localparam int ACC_W   = 64;
    localparam int WIN_W   = 32;
    localparam int PCT_W   = 7;
    localparam int SLOT_W  = 5;
    localparam int USED_W  = 5;
    localparam int STAT_W  = 3;
    localparam int CMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
    localparam int PBIT_W  = $clog2(PCT_W);

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    localparam logic [STAT_W-1:0] ST_ADDED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ   = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNUSED = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ACC_W-1:0] accesses;
        logic [ACC_W-1:0] hits;
        logic [WIN_W-1:0] windows;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

endpackage

[src/pcht_entry_store.sv]
// Entry store: one write port, one registered read port.
// Depends on pcht_pkg (entry_t, mem_wr_t, MAX_ENTRIES, IDX_W).
module pcht_entry_store (
    input  logic                   clk,
    input  pcht_pkg::mem_wr_t      wr,
    input  logic [pcht_pkg::IDX_W-1:0] rd_addr,
    output pcht_pkg::entry_t       rd_data
);

    pcht_pkg::entry_t mem [pcht_pkg::MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/pcht_pct_unit.sv]
// Iterative percent unit: floor(hits*100/accesses) up to 100, one half-step a cycle.
// Depends on pcht_pkg (ACC_W, PCT_W, PBIT_W, PCT_SCALE).
module pcht_pct_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcht_pkg::ACC_W-1:0] hits,
    input  logic [pcht_pkg::ACC_W-1:0] accesses,
    output logic                       done,
    output logic [pcht_pkg::PCT_W-1:0] percent
);

    typedef enum logic [1:0] {
        P_IDLE,
        P_CHECK,
        P_DBL,
        P_ADD
    } pstate_t;

    pstate_t                     state_reg;
    logic [pcht_pkg::ACC_W-1:0]  h_reg;
    logic [pcht_pkg::ACC_W-1:0]  a_reg;
    logic [pcht_pkg::ACC_W-1:0]  amh_reg;
    logic [pcht_pkg::ACC_W-1:0]  r_reg;
    logic [pcht_pkg::PCT_W-1:0]  q_reg;
    logic [pcht_pkg::PBIT_W-1:0] b_reg;
    logic                        done_reg;
    logic [pcht_pkg::PCT_W-1:0]  pct_reg;

    logic [pcht_pkg::ACC_W-1:0]  amr;
    logic                        dbl_ge;
    logic [pcht_pkg::ACC_W-1:0]  r_dbl;
    logic [pcht_pkg::PCT_W-1:0]  q_dbl;
    logic                        add_ge;
    logic [pcht_pkg::ACC_W-1:0]  r_add;
    logic [pcht_pkg::PCT_W-1:0]  q_add;

    // Remainder stays below accesses, so the doubling and adding steps never overflow.
    // The adding step can carry into a quotient bit already set by the doubling step.
    always_comb
    begin
        amr    = a_reg - r_reg;
        dbl_ge = (r_reg >= amr);
        r_dbl  = dbl_ge ? ((r_reg << 1) - a_reg) : (r_reg << 1);
        q_dbl  = {q_reg[pcht_pkg::PCT_W-2:0], dbl_ge};
        add_ge = (r_reg >= amh_reg);
        r_add  = add_ge ? (r_reg - amh_reg) : (r_reg + h_reg);
        q_add  = q_reg + pcht_pkg::PCT_W'(add_ge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= hits;
                        a_reg     <= accesses;
                        state_reg <= P_CHECK;
                    end
                end
                P_CHECK:
                begin
                    priority if (a_reg == '0)
                    begin
                        pct_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else if (h_reg >= a_reg)
                    begin
                        pct_reg   <= pcht_pkg::PCT_SCALE;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        amh_reg   <= a_reg - h_reg;
                        r_reg     <= '0;
                        q_reg     <= '0;
                        b_reg     <= pcht_pkg::PBIT_W'(pcht_pkg::PCT_W - 1);
                        state_reg <= P_DBL;
                    end
                end
                P_DBL:
                begin
                    r_reg <= r_dbl;
                    q_reg <= q_dbl;
                    priority if (pcht_pkg::PCT_SCALE[b_reg])
                    begin
                        state_reg <= P_ADD;
                    end
                    else if (b_reg == '0)
                    begin
                        pct_reg   <= q_dbl;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        b_reg <= b_reg - 1'b1;
                    end
                end
                P_ADD:
                begin
                    r_reg <= r_add;
                    q_reg <= q_add;
                    if (b_reg == '0)
                    begin
                        pct_reg   <= q_add;
                        done_reg  <= 1'b1;
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        b_reg     <= b_reg - 1'b1;
                        state_reg <= P_DBL;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign percent = pct_reg;

endmodule

[src/per_context_hit_counter_table_core.sv]
// Top level of the per-context hit counter table: sequencer, accumulators, result regs.
// Depends on pcht_pkg, pcht_entry_store and pcht_pct_unit.
//
//  Channel  | Direction | Handshake            | Fields
//  ---------+-----------+----------------------+---------------------------------------------
//  command  | in        | start & !busy        | opcode, context_key, window_hits,
//           |           |                      | window_accesses, read_index
//  result   | out       | done, one cycle only | status, entry_slot, access_total, hit_total,
//           |           |                      | window_total, hit_percent, entries_used
//
// Sequence while busy: a record searches the store in order, a registered read and then a
// key compare per used entry checked, plus an allocate step on a miss, then the shared
// percent unit (start, range check, 7 doubling and 3 adding steps, hand-back), the steps
// skipped when there are no accesses or hits reach accesses. The longest case is a hit
// on the last of 24 entries. A drop on a full table skips the percent unit, a read of a
// used entry does a registered read before it, and an unused index never raises busy.
// Reset clears the sequencer and the allocated-entry count; the store is not cleared.
// Stalls: start is ignored while busy; the receiver cannot hold a result off, and a
// new transaction is taken in the same cycle that a result is shown.
module per_context_hit_counter_table_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [pcht_pkg::KEY_W-1:0]  context_key,
    input  logic [pcht_pkg::WCNT_W-1:0] window_hits,
    input  logic [pcht_pkg::WCNT_W-1:0] window_accesses,
    input  logic [pcht_pkg::SLOT_W-1:0] read_index,
    output logic                        done,
    output logic [pcht_pkg::STAT_W-1:0] status,
    output logic [pcht_pkg::SLOT_W-1:0] entry_slot,
    output logic [pcht_pkg::ACC_W-1:0]  access_total,
    output logic [pcht_pkg::ACC_W-1:0]  hit_total,
    output logic [pcht_pkg::WIN_W-1:0]  window_total,
    output logic [pcht_pkg::PCT_W-1:0]  hit_percent,
    output logic [pcht_pkg::USED_W-1:0] entries_used
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_WAIT,
        S_SRCH_CMP,
        S_ALLOC,
        S_RD_WAIT,
        S_RD_DATA,
        S_DIV_START,
        S_DIV_WAIT
    } state_t;

    state_t                        state_reg;
    logic [pcht_pkg::KEY_W-1:0]    key_reg;
    logic [pcht_pkg::WCNT_W-1:0]   whits_reg;
    logic [pcht_pkg::WCNT_W-1:0]   waccs_reg;
    logic [pcht_pkg::IDX_W-1:0]    idx_reg;
    logic [pcht_pkg::CNT_W-1:0]    used_reg;
    logic [pcht_pkg::STAT_W-1:0]   status_reg;
    logic [pcht_pkg::SLOT_W-1:0]   slot_reg;
    logic [pcht_pkg::ACC_W-1:0]    acc_reg;
    logic [pcht_pkg::ACC_W-1:0]    hit_reg;
    logic [pcht_pkg::WIN_W-1:0]    win_reg;
    logic [pcht_pkg::PCT_W-1:0]    pct_reg;
    logic                          done_reg;

    pcht_pkg::mem_wr_t             wr;
    pcht_pkg::entry_t              rd_data;
    logic                          pct_start;
    logic                          pct_done;
    logic [pcht_pkg::PCT_W-1:0]    pct_value;

    logic                          accept;
    logic                          key_hit;
    logic                          last_entry;
    logic                          full;
    logic                          alloc;
    logic [pcht_pkg::ACC_W-1:0]    base_acc;
    logic [pcht_pkg::ACC_W-1:0]    base_hit;
    logic [pcht_pkg::WIN_W-1:0]    base_win;
    logic [pcht_pkg::ACC_W-1:0]    sum_acc;
    logic [pcht_pkg::ACC_W-1:0]    sum_hit;
    logic [pcht_pkg::WIN_W-1:0]    sum_win;

    pcht_entry_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    pcht_pct_unit u_pct (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pct_start),
        .hits     (hit_reg),
        .accesses (acc_reg),
        .done     (pct_done),
        .percent  (pct_value)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign pct_start = (state_reg == S_DIV_START);

    // One shared set of adders serves both a hit (stored totals) and a fresh entry (zero).
    always_comb
    begin
        alloc      = (state_reg == S_ALLOC);
        key_hit    = (rd_data.key == key_reg);
        last_entry = ((pcht_pkg::CNT_W'(idx_reg) + pcht_pkg::CNT_W'(1)) == used_reg);
        full       = (used_reg == pcht_pkg::CNT_W'(pcht_pkg::MAX_ENTRIES));
        base_acc   = alloc ? '0 : rd_data.accesses;
        base_hit   = alloc ? '0 : rd_data.hits;
        base_win   = alloc ? '0 : rd_data.windows;
        sum_acc    = base_acc + pcht_pkg::ACC_W'(waccs_reg);
        sum_hit    = base_hit + pcht_pkg::ACC_W'(whits_reg);
        sum_win    = base_win + pcht_pkg::WIN_W'(1);

        wr.en            = ((state_reg == S_SRCH_CMP) && key_hit) || (alloc && !full);
        wr.addr          = alloc ? used_reg[pcht_pkg::IDX_W-1:0] : idx_reg;
        wr.data.key      = key_reg;
        wr.data.accesses = sum_acc;
        wr.data.hits     = sum_hit;
        wr.data.windows  = sum_win;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg   <= context_key;
                        whits_reg <= window_hits;
                        waccs_reg <= window_accesses;
                        priority if (opcode)
                        begin
                            slot_reg <= read_index;
                            idx_reg  <= pcht_pkg::IDX_W'(read_index);
                            if (pcht_pkg::CMP_W'(read_index) < pcht_pkg::CMP_W'(used_reg))
                            begin
                                state_reg <= S_RD_WAIT;
                            end
                            else
                            begin
                                // Unused position: echo the index, zero the totals.
                                status_reg <= pcht_pkg::ST_UNUSED;
                                acc_reg    <= '0;
                                hit_reg    <= '0;
                                win_reg    <= '0;
                                pct_reg    <= '0;
                                done_reg   <= 1'b1;
                            end
                        end
                        else if (used_reg == '0)
                        begin
                            state_reg <= S_ALLOC;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_SRCH_WAIT;
                        end
                    end
                end
                S_SRCH_WAIT:
                begin
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP:
                begin
                    priority if (key_hit)
                    begin
                        status_reg <= pcht_pkg::ST_ADDED;
                        slot_reg   <= pcht_pkg::SLOT_W'(idx_reg);
                        acc_reg    <= sum_acc;
                        hit_reg    <= sum_hit;
                        win_reg    <= sum_win;
                        state_reg  <= S_DIV_START;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= S_ALLOC;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRCH_WAIT;
                    end
                end
                S_ALLOC:
                begin
                    if (full)
                    begin
                        // Table full: drop the window and report zeros.
                        status_reg <= pcht_pkg::ST_FULL;
                        slot_reg   <= '0;
                        acc_reg    <= '0;
                        hit_reg    <= '0;
                        win_reg    <= '0;
                        pct_reg    <= '0;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        status_reg <= pcht_pkg::ST_NEW;
                        slot_reg   <= pcht_pkg::SLOT_W'(used_reg);
                        acc_reg    <= sum_acc;
                        hit_reg    <= sum_hit;
                        win_reg    <= sum_win;
                        used_reg   <= used_reg + pcht_pkg::CNT_W'(1);
                        state_reg  <= S_DIV_START;
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA:
                begin
                    status_reg <= pcht_pkg::ST_READ;
                    acc_reg    <= rd_data.accesses;
                    hit_reg    <= rd_data.hits;
                    win_reg    <= rd_data.windows;
                    state_reg  <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (pct_done)
                    begin
                        pct_reg   <= pct_value;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign entry_slot   = slot_reg;
    assign access_total = acc_reg;
    assign hit_total    = hit_reg;
    assign window_total = win_reg;
    assign hit_percent  = pct_reg;
    assign entries_used = pcht_pkg::USED_W'(used_reg);

    // Allocated count never passes the table size and grows by at most one per edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pcht_pkg::CNT_W'(entries_used) <= pcht_pkg::CNT_W'(pcht_pkg::MAX_ENTRIES)))
        else $error("entries_used exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (entries_used == $past(entries_used)) ||
        (entries_used == $past(entries_used) + 1'b1))
        else $error("entries_used changed by more than one");

    // A freshly allocated entry reports exactly one window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == pcht_pkg::ST_NEW)) |-> (window_total == pcht_pkg::WIN_W'(1)))
        else $error("new entry does not report one window");

    // Dropped and unused-index results carry zero totals.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == pcht_pkg::ST_FULL) || (status == pcht_pkg::ST_UNUSED))) |->
        ((access_total == '0) && (hit_total == '0) && (hit_percent == '0)))
        else $error("dropped or unused result has nonzero totals");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_percent <= pcht_pkg::PCT_SCALE))
        else $error("hit_percent above 100");

endmodule
